// ===== src/pdmd_pkg.sv =====
// Package for the pattern delta mask decoder: payload structs, phase codes,
// register indexes and the per-byte operation passed from parser to store.
// No dependencies.
`timescale 1ns / 1ps

package pdmd_pkg;

	localparam int MAX_CHANNELS_DEF = 64;
	localparam int CHAN_W           = 7;
	localparam int ROWCNT_W         = 11;
	localparam int CFG_IDX_W        = 1;
	localparam int CFG_DATA_W       = 11;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 1'b1;

	localparam logic [7:0] MASK_FLAG  = 8'h80;
	localparam logic [7:0] FIELD_BITS = 8'h3F;
	localparam logic [7:0] EXTRA_BIT  = 8'h40;

	localparam int FIELD_NUM = 6;

	typedef logic [FIELD_NUM-1:0][7:0] cell_t;

	typedef enum logic [2:0] {
		PH_CHAN,
		PH_MASK,
		PH_FIELD,
		PH_LEN,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic       is_cell;
		logic       pattern_done;
		logic [9:0] row_index;
		logic [5:0] channel_index;
		logic [7:0] note_value;
		logic [7:0] instrument_value;
		logic [7:0] volume_command;
		logic [7:0] volume_value;
		logic [7:0] effect_command;
		logic [7:0] effect_param;
	} result_t;

	// One parsed byte's work for the store stage.
	typedef struct packed {
		logic              clear;
		logic              load;
		logic              wr;
		logic [2:0]        idx;
		logic [7:0]        wbyte;
		logic              emit_cell;
		logic              emit_done;
		logic [CHAN_W-1:0] addr;
		logic [9:0]        row;
	} op_t;

	// Lowest set field bit: {found, index}.
	function automatic logic [3:0] first_field(input logic [FIELD_NUM-1:0] m);
		logic [3:0] r;
		r = 4'd0;
		for (int i = FIELD_NUM - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = {1'b1, 3'(i)};
			end
		end
		return r;
	endfunction

endpackage

// ===== src/pdmd_front.sv =====
// Byte parser of the pattern decoder: phase machine, row counter and the
// stage-1 operation register. Depends on pdmd_pkg.
`timescale 1ns / 1ps

module pdmd_front import pdmd_pkg::*; #(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  item_t               item,
	input  logic [CHAN_W-1:0]   channel_count,
	input  logic [ROWCNT_W-1:0] row_count,
	input  logic                adv,
	output logic                op_valid_s1,
	output op_t                 op_s1,
	output logic                rd_en,
	output logic [CHAN_W-1:0]   rd_addr
);

	phase_t              phase_q, phase_n;
	logic [CHAN_W-1:0]   chan_q, chan_n;
	logic [ROWCNT_W-1:0] row_q, row_n;
	logic [7:0]          mask_q, mask_n;
	logic [7:0]          skip_q, skip_n;
	logic                new_valid;
	op_t                 new_op;
	logic [CHAN_W-1:0]   eff;
	logic [CHAN_W-1:0]   ch_dec;
	logic                cur_ok;
	logic                new_ok;
	logic [3:0]          ff;
	logic                accept;
	logic [7:0]          b;

	assign accept     = item_valid && !item_stall;
	assign item_stall = op_valid_s1 && !adv;
	assign b          = item.data_byte;
	assign eff        = (channel_count < CHAN_W'(MAX_CHANNELS)) ? channel_count
	                                                             : CHAN_W'(MAX_CHANNELS);
	assign cur_ok     = chan_q < eff;
	assign ch_dec     = (b[6:0] != 7'd0) ? CHAN_W'(b[6:0] - 7'd1) : CHAN_W'(0);
	assign new_ok     = ch_dec < eff;
	assign ff         = first_field(mask_q[FIELD_NUM-1:0]);

	always_comb begin
		phase_n   = phase_q;
		chan_n    = chan_q;
		row_n     = row_q;
		mask_n    = mask_q;
		skip_n    = skip_q;
		new_valid = 1'b0;
		new_op    = '0;
		rd_en     = 1'b0;
		rd_addr   = ch_dec;
		if (item.kind) begin
			phase_n      = PH_CHAN;
			chan_n       = '0;
			row_n        = '0;
			mask_n       = '0;
			skip_n       = '0;
			new_valid    = 1'b1;
			new_op.clear = 1'b1;
		end else if (row_q < row_count) begin
			unique case (phase_q)
				PH_CHAN: begin
					if (b == 8'd0) begin
						row_n = row_q + ROWCNT_W'(1);
						if (row_n >= row_count) begin
							new_valid        = 1'b1;
							new_op.emit_done = 1'b1;
						end
					end else begin
						chan_n = ch_dec;
						mask_n = '0;
						if (new_ok) begin
							// read only on the accepting edge so held read data stays put
							rd_en       = accept;
							new_valid   = 1'b1;
							new_op.load = 1'b1;
						end
						if ((b & MASK_FLAG) != 8'd0) begin
							phase_n = PH_MASK;
						end else begin
							// no mask: emit the remembered cell right away
							new_op.emit_cell = new_ok;
							phase_n          = PH_CHAN;
						end
					end
				end
				PH_MASK: begin
					mask_n = b & (FIELD_BITS | EXTRA_BIT);
					if ((mask_n & FIELD_BITS) != 8'd0) begin
						phase_n = PH_FIELD;
					end else begin
						new_valid        = cur_ok;
						new_op.emit_cell = cur_ok;
						phase_n          = ((mask_n & EXTRA_BIT) != 8'd0) ? PH_LEN : PH_CHAN;
					end
				end
				PH_FIELD: begin
					if (ff[3]) begin
						new_op.wr    = cur_ok;
						new_op.idx   = ff[2:0];
						new_op.wbyte = b;
						new_valid    = cur_ok;
						mask_n[ff[2:0]] = 1'b0;
					end
					if ((mask_n & FIELD_BITS) == 8'd0) begin
						new_valid        = cur_ok;
						new_op.emit_cell = cur_ok;
						phase_n          = ((mask_n & EXTRA_BIT) != 8'd0) ? PH_LEN : PH_CHAN;
					end
				end
				PH_LEN: begin
					skip_n  = b;
					phase_n = (b == 8'd0) ? PH_CHAN : PH_SKIP;
				end
				PH_SKIP: begin
					if (skip_q != 8'd0) begin
						skip_n = skip_q - 8'd1;
					end
					if (skip_n == 8'd0) begin
						phase_n = PH_CHAN;
					end
				end
				default: begin
					phase_n = PH_CHAN;
				end
			endcase
		end
		new_op.addr = chan_n;
		new_op.row  = row_q[9:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CHAN;
			chan_q  <= '0;
			row_q   <= '0;
			mask_q  <= '0;
			skip_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			chan_q  <= chan_n;
			row_q   <= row_n;
			mask_q  <= mask_n;
			skip_q  <= skip_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_s1 <= 1'b0;
		end else if (accept) begin
			op_valid_s1 <= new_valid;
		end else if (adv) begin
			op_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= new_op;
		end
	end

endmodule

// ===== src/pdmd_store.sv =====
// Per-channel last-value memory with valid bits, write-to-read forwarding
// and the cell under build. Depends on pdmd_pkg.
`timescale 1ns / 1ps

module pdmd_store import pdmd_pkg::*; #(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  op_t               op,
	input  logic              adv,
	input  logic              rd_en,
	input  logic [CHAN_W-1:0] rd_addr,
	output cell_t             cell_next
);

	localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	cell_t                   mem [MAX_CHANNELS];
	cell_t                   rdata_q;
	cell_t                   fwd_data_q;
	logic                    fwd_q;
	cell_t                   cell_q;
	logic [MAX_CHANNELS-1:0] vld_q;
	logic [AW-1:0]           waddr;
	logic [AW-1:0]           raddr;
	logic                    we;
	cell_t                   base;

	assign waddr = op.addr[AW-1:0];
	assign raddr = rd_addr[AW-1:0];
	assign we    = adv && op.wr;

	always_comb begin
		if (op.load) begin
			if (fwd_q) begin
				base = fwd_data_q;
			end else if (vld_q[waddr]) begin
				base = rdata_q;
			end else begin
				base = '0;
			end
		end else begin
			base = cell_q;
		end
		cell_next = base;
		if (op.wr) begin
			cell_next[op.idx] = op.wbyte;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= cell_next;
		end
		if (rd_en) begin
			rdata_q    <= mem[raddr];
			fwd_data_q <= cell_next;
		end
		if (adv) begin
			cell_q <= cell_next;
		end
	end

	// forward when the read lands on the entry being written at the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= we && (waddr == raddr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv && op.clear) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_valid && op.clear |=> vld_q == '0)
		else $error("valid bits not cleared by start");
	a_write_marks: assert property (@(posedge clk) disable iff (!arst_n)
		we && op_valid |=> vld_q[$past(waddr)])
		else $error("written entry not marked valid");
	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && op.load && !adv |=> $stable(rdata_q) && $stable(fwd_q))
		else $error("read data lost while load is held");
`endif

endmodule

// ===== src/pattern_delta_mask_decoder_unit.sv =====
// Top level of the pattern delta mask decoder: configuration registers,
// parser, last-value store and result register. Depends on pdmd_pkg,
// pdmd_front and pdmd_store.
//   Throughput: one byte request per cycle, sustained while result_stall is low.
//   Pipeline: two register stages (parse, then store read-modify-write into the
//   result register); a result waits in the stage-1 register while the result slot is full.
//   The store read issued as a channel byte is accepted returns in the next
//   cycle and sets the pipeline depth.
//   Reset: arst_n clears control state and all channel valid bits at once;
//   a start request clears them at once as it advances through the store stage, no clearing pass.
`timescale 1ns / 1ps

module pattern_delta_mask_decoder_unit import pdmd_pkg::*; #(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CHAN_W-1:0]   channel_count_q;
	logic [ROWCNT_W-1:0] row_count_q;
	logic                op_valid_s1;
	op_t                 op_s1;
	logic                rd_en;
	logic [CHAN_W-1:0]   rd_addr;
	cell_t               cell_next;
	logic                out_free;
	logic                emits;
	logic                adv;
	result_t             res_n;

	// Configuration always taken; users change it only while the block is idle, unenforced.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= CHAN_W'(64);
			row_count_q     <= ROWCNT_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[CHAN_W-1:0];
				REG_ROW_COUNT:     row_count_q     <= cfg_data[ROWCNT_W-1:0];
				default:           row_count_q     <= row_count_q;
			endcase
		end
	end

	// Parse stage: phase machine and the stage-1 operation register.
	pdmd_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.channel_count(channel_count_q),
		.row_count    (row_count_q),
		.adv          (adv),
		.op_valid_s1  (op_valid_s1),
		.op_s1        (op_s1),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr)
	);

	// Store stage: merge read data into the cell, write back field updates.
	pdmd_store #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid_s1),
		.op       (op_s1),
		.adv      (adv),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.cell_next(cell_next)
	);

	// Advance the store stage unless it must emit and the result slot is full.
	assign out_free = !result_valid || !result_stall;
	assign emits    = op_s1.emit_cell || op_s1.emit_done;
	assign adv      = op_valid_s1 && (!emits || out_free);

	always_comb begin
		res_n = '0;
		if (op_s1.emit_done) begin
			res_n.pattern_done = 1'b1;
		end else begin
			res_n.is_cell          = 1'b1;
			res_n.row_index        = op_s1.row;
			res_n.channel_index    = op_s1.addr[5:0];
			res_n.note_value       = cell_next[0];
			res_n.instrument_value = cell_next[1];
			res_n.volume_command   = cell_next[2];
			res_n.volume_value     = cell_next[3];
			res_n.effect_command   = cell_next[4];
			res_n.effect_param     = cell_next[5];
		end
	end

	// Result register: load on an emitting advance, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv && emits) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emits) begin
			result <= res_n;
		end
	end

endmodule
